// ----- hw/rtl/nkdt_pkg.sv -----
// Shared types and constants of the name-keyed directory table.
package nkdt_pkg;

  localparam int unsigned KEY_W      = 64;
  localparam int unsigned KEY_BYTES  = KEY_W / 8;
  localparam int unsigned SECTOR_W   = 16;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned INDEX_W    = 6;
  localparam int unsigned SIZE_OUT_W = 7;
  localparam int unsigned CFG_W      = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FIND   = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_REMOVE = 2'd2
  } nkdt_action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } nkdt_status_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    name_key;
    logic [SECTOR_W-1:0] sector;
  } nkdt_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [INDEX_W-1:0]    entry_index;
    logic [SECTOR_W-1:0]   found_sector;
    logic [SIZE_OUT_W-1:0] active_entries;
  } nkdt_rsp_t;

  // Search token that walks down the row of cells, one cell per cycle.
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic                free;
    logic [SECTOR_W-1:0] sector;
  } nkdt_tok_t;

  // Write-back command broadcast to all cells.
  typedef struct packed {
    logic                set_valid;
    logic                clr_valid;
    logic                clear_all;
    logic [KEY_W-1:0]    name;
    logic [SECTOR_W-1:0] sector;
  } nkdt_cmd_t;

endpackage

// ----- hw/rtl/name_keyed_directory_table_top.sv -----
// Top level of the name-keyed directory table: control and the row of entry cells.
//
// Usage. A request (action, name key, sector) enters on the req channel with
// valid and ready; one response (status, entry index, found sector, active
// entries) leaves on the rsp channel for every request. The cfg channel writes
// initial_size; a write clears every entry and loads the active size with the
// value clamped to 1..CAPACITY. Writes are taken at any time but belong in idle.
// One request is in flight at a time while the search token walks the row of
// cells one cell per cycle; the next request can be taken in the cycle that the
// response appears.
// The response sits in an output register, so a new request is accepted while
// the previous response still waits; only the final write-back step waits for
// that register to drain when the receiver stalls.
// Reset clears all valid marks and sets the active size to 10 (clamped), with
// no clearing pass; entry names and sectors are only read behind valid marks.
module name_keyed_directory_table_top #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned GROW_STEP  = 8,
  parameter int unsigned NAME_BYTES = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  nkdt_pkg::nkdt_req_t          req_i,
  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output nkdt_pkg::nkdt_rsp_t          rsp_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [nkdt_pkg::CFG_W-1:0]   cfg_data_i
);
  import nkdt_pkg::*;

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned SIZE_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W  = $clog2(CAPACITY + GROW_STEP + 1);
  localparam int unsigned RESET_SIZE_INT = (10 > CAPACITY) ? CAPACITY : 10;
  localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(RESET_SIZE_INT);
  localparam logic [SIZE_W-1:0] CAP_SIZE   = SIZE_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_SCAN,
    S_FINISH
  } state_e;

  // Only the first NAME_BYTES bytes count, and the name ends at its first zero byte.
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] o;
    logic             live;
    o    = '0;
    live = 1'b1;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if ((b >= NAME_BYTES) || (k[8*b +: 8] == 8'd0)) begin
        live = 1'b0;
      end
      if (live) begin
        o[8*b +: 8] = k[8*b +: 8];
      end
    end
    return o;
  endfunction

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > CFG_W'(CAPACITY > 127 ? 127 : CAPACITY)) begin
      r = CAP_SIZE;
    end else begin
      r = SIZE_W'(v);
    end
    return r;
  endfunction

  state_e              state_q, state_d;
  logic [ACTION_W-1:0] act_q;
  logic [KEY_W-1:0]    key_q;
  logic [SECTOR_W-1:0] sector_q;
  logic [SIZE_W-1:0]   active_q, active_d;
  logic                rsp_valid_q, rsp_valid_d;
  nkdt_rsp_t           rsp_q, rsp_d;

  // Search result captured when the token leaves the last cell.
  logic                res_hit_q, res_free_q;
  logic [SECTOR_W-1:0] res_sector_q;
  logic [IDX_W-1:0]    res_hit_idx_q, res_free_idx_q;

  nkdt_tok_t        tok      [0:CAPACITY];
  logic [IDX_W-1:0] hit_idx  [0:CAPACITY];
  logic [IDX_W-1:0] free_idx [0:CAPACITY];

  nkdt_cmd_t        cmd;
  logic [IDX_W-1:0] cmd_idx;

  logic             req_acc, cfg_acc, fin_go, tail_valid;
  logic [SUM_W-1:0] grown;

  assign req_ready_o = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign req_acc     = req_valid_i && req_ready_o;
  assign cfg_acc     = cfg_valid_i;
  assign fin_go      = (state_q == S_FINISH) && (!rsp_valid_q || rsp_ready_i);
  assign tail_valid  = tok[CAPACITY].valid;

  // A fresh token enters the first cell in the launch cycle.
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = (state_q == S_LAUNCH);
  end
  assign hit_idx[0]  = '0;
  assign free_idx[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    nkdt_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (IDX_W'(i)),
      .active_i   (active_q > SIZE_W'(i)),
      .key_i      (key_q),
      .tok_i      (tok[i]),
      .hit_idx_i  (hit_idx[i]),
      .free_idx_i (free_idx[i]),
      .tok_o      (tok[i+1]),
      .hit_idx_o  (hit_idx[i+1]),
      .free_idx_o (free_idx[i+1]),
      .cmd_i      (cmd),
      .cmd_idx_i  (cmd_idx)
    );
  end

  // Size after a growth step, limited to the physical capacity.
  always_comb begin
    grown = SUM_W'(active_q) + SUM_W'(GROW_STEP);
    if (grown > SUM_W'(CAPACITY)) begin
      grown = SUM_W'(CAPACITY);
    end
  end

  // Sequence the states, decide the result and the write-back of the finished search, and apply configuration writes.
  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    rsp_d       = rsp_q;
    cmd         = '0;
    cmd_idx     = '0;

    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          state_d = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (tail_valid) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fin_go) begin
          rsp_d.status       = ST_NOT_FOUND;
          rsp_d.entry_index  = '0;
          rsp_d.found_sector = '0;
          case (nkdt_action_e'(act_q))
            ACT_FIND: begin
              if (res_hit_q) begin
                rsp_d.status       = ST_OK;
                rsp_d.entry_index  = INDEX_W'(res_hit_idx_q);
                rsp_d.found_sector = res_sector_q;
              end
            end
            ACT_ADD: begin
              if (res_hit_q) begin
                rsp_d.status = ST_DUPLICATE;
              end else if (res_free_q) begin
                cmd.set_valid     = 1'b1;
                cmd_idx           = res_free_idx_q;
                rsp_d.status      = ST_OK;
                rsp_d.entry_index = INDEX_W'(res_free_idx_q);
              end else if (active_q < CAP_SIZE) begin
                // The first of the new entries takes the name; the rest stay free.
                cmd.set_valid     = 1'b1;
                cmd_idx           = IDX_W'(active_q);
                active_d          = SIZE_W'(grown);
                rsp_d.status      = ST_OK;
                rsp_d.entry_index = INDEX_W'(active_q);
              end else begin
                rsp_d.status = ST_FULL;
              end
            end
            ACT_REMOVE: begin
              if (res_hit_q) begin
                cmd.clr_valid     = 1'b1;
                cmd_idx           = res_hit_idx_q;
                rsp_d.status      = ST_OK;
                rsp_d.entry_index = INDEX_W'(res_hit_idx_q);
              end
            end
            default: begin
            end
          endcase
          cmd.name             = key_q;
          cmd.sector           = sector_q;
          rsp_d.active_entries = SIZE_OUT_W'(active_d);
          rsp_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A configuration write reformats the table.
    if (cfg_acc) begin
      cmd.clear_all = 1'b1;
      active_d      = clamp_size(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= RESET_SIZE;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      act_q    <= req_i.action;
      key_q    <= norm_key(req_i.name_key);
      sector_q <= req_i.sector;
    end
    if ((state_q == S_SCAN) && tail_valid) begin
      res_hit_q      <= tok[CAPACITY].hit;
      res_free_q     <= tok[CAPACITY].free;
      res_sector_q   <= tok[CAPACITY].sector;
      res_hit_idx_q  <= hit_idx[CAPACITY];
      res_free_idx_q <= free_idx[CAPACITY];
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ----- hw/rtl/nkdt_cell.sv -----
// One table entry with its stage of the search token chain.
module nkdt_cell #(
  parameter int unsigned IDX_W = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [IDX_W-1:0]         idx_i,
  input  logic                     active_i,
  input  logic [nkdt_pkg::KEY_W-1:0] key_i,
  input  nkdt_pkg::nkdt_tok_t      tok_i,
  input  logic [IDX_W-1:0]         hit_idx_i,
  input  logic [IDX_W-1:0]         free_idx_i,
  output nkdt_pkg::nkdt_tok_t      tok_o,
  output logic [IDX_W-1:0]         hit_idx_o,
  output logic [IDX_W-1:0]         free_idx_o,
  input  nkdt_pkg::nkdt_cmd_t      cmd_i,
  input  logic [IDX_W-1:0]         cmd_idx_i
);
  import nkdt_pkg::*;

  logic                valid_q;
  logic [KEY_W-1:0]    name_q;
  logic [SECTOR_W-1:0] sector_q;
  nkdt_tok_t           tok_d, tok_q;
  logic [IDX_W-1:0]    hit_idx_d, hit_idx_q;
  logic [IDX_W-1:0]    free_idx_d, free_idx_q;
  logic                sel;

  assign sel = (cmd_idx_i == idx_i);

  // The first matching cell and the first free active cell mark the token.
  always_comb begin
    tok_d      = tok_i;
    hit_idx_d  = hit_idx_i;
    free_idx_d = free_idx_i;
    if (tok_i.valid && !tok_i.hit && valid_q && (name_q == key_i)) begin
      tok_d.hit    = 1'b1;
      tok_d.sector = sector_q;
      hit_idx_d    = idx_i;
    end
    if (tok_i.valid && !tok_i.free && !valid_q && active_i) begin
      tok_d.free = 1'b1;
      free_idx_d = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (cmd_i.clear_all) begin
        valid_q <= 1'b0;
      end else if (sel && cmd_i.set_valid) begin
        valid_q <= 1'b1;
      end else if (sel && cmd_i.clr_valid) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (sel && cmd_i.set_valid) begin
      name_q   <= cmd_i.name;
      sector_q <= cmd_i.sector;
    end
  end

  assign tok_o      = tok_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;

endmodule
